// ===== rtl/core/fat12_pkg.sv =====
package fat12_pkg;

	// operation codes of an input item
	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_OPEN = 2'd1,
		OP_ROOT = 2'd2,
		OP_READ = 2'd3
	} op_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_SPC       = 2'd0,
		REG_DATA_LBA  = 2'd1,
		REG_ROOT_LBA  = 2'd2,
		REG_ROOT_SIZE = 2'd3
	} reg_idx_t;

	localparam int FAT_BYTES_DEF      = 8192;
	localparam int MAX_READ_BYTES_DEF = 16384;
	localparam int SECTOR_BYTES       = 512;

	localparam logic [11:0] CHAIN_END  = 12'hFF8;
	localparam logic [11:0] ENTRY_MASK = 12'hFFF;

	localparam logic [7:0]  SPC_RST       = 8'd1;
	localparam logic [31:0] DATA_LBA_RST  = 32'd33;
	localparam logic [31:0] ROOT_LBA_RST  = 32'd19;
	localparam logic [20:0] ROOT_SIZE_RST = 21'd7168;

	localparam logic [7:0]  SPC_MAX = 8'd128;

endpackage

// ===== rtl/core/fat12_ram.sv =====
module fat12_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/fat12_file_sector_walker.sv =====
// FAT12 file sector walker: keeps the FAT12 allocation table in a byte RAM
// (loaded one byte per item) and the read state of one open file or of the
// fixed root directory. An open item answers with one item asking for the
// first sector; a read item is cut into copy segments that never cross the
// 512-byte sector buffer, and each segment that ends on a sector boundary
// carries the LBA of the next sector, found by stepping the root LBA, by
// stepping within the same cluster or by following the 12-bit cluster chain
// through the table RAM. A chain entry of 0xFF8 or more, or the end of the
// root directory, ends the read with end_of_file. A table load keeps
// in_ready high. An open passes the multiply, add and emit states (a root
// open goes straight to emit). A read clamps its count; then a segment
// inside a sector or in the root directory is cut and emitted, one that
// crosses into the next sector of the same cluster also passes the check,
// multiply and add states, and where the chain is followed the FAT entry is
// fetched as two bytes through the single read port of the table RAM, then
// one shared 13x9 multiplier forms the cluster LBA. A full 16384-byte file
// read has up to 33 segments. in_ready is low while a read or open is in
// work, and each segment also waits for the output register to be free. The
// table RAM has no clearing pass; its entries are undefined until loaded.
module fat12_file_sector_walker
	import fat12_pkg::*;
#(
	parameter int FAT_BYTES      = FAT_BYTES_DEF,
	parameter int MAX_READ_BYTES = MAX_READ_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [12:0] table_index,
	input  logic [7:0]  table_byte,
	input  logic [11:0] start_cluster,
	input  logic [31:0] file_bytes,
	input  logic        is_directory,
	input  logic [14:0] byte_count,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [8:0]  copy_offset,
	output logic [9:0]  copy_length,
	output logic        fetch_valid,
	output logic [31:0] fetch_lba,
	output logic        end_of_file,
	output logic        last
);

	localparam int FAT_AW = $clog2(FAT_BYTES);
	localparam logic [13:0] FAT_LIM = 14'(FAT_BYTES);
	localparam logic [14:0] MAX_RD  = 15'(MAX_READ_BYTES);
	localparam logic [9:0]  SECT    = 10'(SECTOR_BYTES);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLAMP,
		ST_SEG,
		ST_CH_A,
		ST_CH_B,
		ST_CH_C,
		ST_CHK,
		ST_MUL,
		ST_ADD,
		ST_EMIT
	} state_t;

	state_t state_q;

	// configuration registers
	logic [7:0]  spc_q;
	logic [31:0] data_lba_q;
	logic [31:0] root_lba_q;
	logic [20:0] root_size_q;

	// open object state
	logic [31:0] cur_q;   // cluster, or the current LBA in root mode
	logic [6:0]  sic_q;
	logic [31:0] pos_q;
	logic [31:0] size_q;
	logic        dir_q;
	logic        root_q;

	// read work registers
	logic [14:0] cnt_q;
	logic [7:0]  lo_q;
	logic signed [21:0] prod_q;

	// pending result
	logic [8:0]  p_off_q;
	logic [9:0]  p_len_q;
	logic        p_fv_q;
	logic [31:0] p_lba_q;
	logic        p_eof_q;
	logic        p_last_q;

	// output register
	logic        ov_q;
	logic [8:0]  o_off_q;
	logic [9:0]  o_len_q;
	logic        o_fv_q;
	logic [31:0] o_lba_q;
	logic        o_eof_q;
	logic        o_last_q;

	logic in_acc;
	logic out_free;

	// segment arithmetic
	logic [8:0]  seg_off;
	logic [9:0]  seg_room;
	logic [9:0]  seg_take;
	logic [31:0] seg_pos;
	logic [14:0] seg_cnt;
	logic        seg_bound;
	logic [31:0] left;
	logic [14:0] cnt_sat;

	// cluster arithmetic
	logic [7:0]  spc_eff;
	logic [7:0]  sic_nxt;
	logic signed [12:0] cl_m2;
	logic signed [8:0]  spc_s;
	logic [31:0] lba_sum;

	// chain lookup
	logic [12:0] fidx;
	logic [13:0] fidx_lo;
	logic [13:0] fidx_hi;
	logic        hi_ok;
	logic [7:0]  hi_byte;
	logic [15:0] entry_word;
	logic [11:0] entry_nxt;

	// table RAM
	logic              ram_we;
	logic [FAT_AW-1:0] ram_raddr;
	logic [7:0]        ram_rdata;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_free = !ov_q || out_ready;

	assign out_valid   = ov_q;
	assign copy_offset = o_off_q;
	assign copy_length = o_len_q;
	assign fetch_valid = o_fv_q;
	assign fetch_lba   = o_lba_q;
	assign end_of_file = o_eof_q;
	assign last        = o_last_q;

	always_comb begin
		// request saturation and clamp to the bytes left in a plain file
		cnt_sat = (byte_count > MAX_RD) ? MAX_RD : byte_count;
		left    = (pos_q < size_q) ? (size_q - pos_q) : 32'd0;

		// one segment: never past the end of the sector buffer
		seg_off   = pos_q[8:0];
		seg_room  = SECT - {1'b0, seg_off};
		seg_take  = ({5'd0, seg_room} > cnt_q) ? cnt_q[9:0] : seg_room;
		seg_pos   = pos_q + {22'd0, seg_take};
		seg_cnt   = cnt_q - {5'd0, seg_take};
		seg_bound = (seg_take == seg_room);

		// cluster size out of range is pulled into 1..128
		if (spc_q == 8'd0) begin
			spc_eff = 8'd1;
		end else if (spc_q > SPC_MAX) begin
			spc_eff = SPC_MAX;
		end else begin
			spc_eff = spc_q;
		end
		sic_nxt = {1'b0, sic_q} + 8'd1;

		// (cluster - 2) is signed so clusters below two wrap like the data lba
		cl_m2   = $signed({1'b0, cur_q[11:0]}) - 13'sd2;
		spc_s   = $signed({1'b0, spc_eff});
		lba_sum = data_lba_q + {{10{prod_q[21]}}, prod_q} + {25'd0, sic_q};

		// 12-bit entry at byte offset cluster * 3 / 2
		fidx       = {1'b0, cur_q[11:0]} + {2'b00, cur_q[11:1]};
		fidx_lo    = {1'b0, fidx};
		fidx_hi    = fidx_lo + 14'd1;
		hi_ok      = (fidx_hi < FAT_LIM);
		hi_byte    = hi_ok ? ram_rdata : 8'd0;
		entry_word = {hi_byte, lo_q};
		entry_nxt  = cur_q[0] ? entry_word[15:4] : (entry_word[11:0] & ENTRY_MASK);

		ram_we = in_acc && (op_t'(operation) == OP_LOAD) && ({1'b0, table_index} < FAT_LIM);
		if (state_q == ST_CH_B) begin
			ram_raddr = fidx_hi[FAT_AW-1:0];
		end else begin
			ram_raddr = fidx_lo[FAT_AW-1:0];
		end
	end

	fat12_ram #(
		.WIDTH (8),
		.DEPTH (FAT_BYTES)
	) u_fat_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (table_index[FAT_AW-1:0]),
		.wdata (table_byte),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			spc_q       <= SPC_RST;
			data_lba_q  <= DATA_LBA_RST;
			root_lba_q  <= ROOT_LBA_RST;
			root_size_q <= ROOT_SIZE_RST;
			cur_q       <= '0;
			sic_q       <= '0;
			pos_q       <= '0;
			size_q      <= '0;
			dir_q       <= 1'b0;
			root_q      <= 1'b0;
			cnt_q       <= '0;
			lo_q        <= '0;
			prod_q      <= '0;
			p_off_q     <= '0;
			p_len_q     <= '0;
			p_fv_q      <= 1'b0;
			p_lba_q     <= '0;
			p_eof_q     <= 1'b0;
			p_last_q    <= 1'b0;
			ov_q        <= 1'b0;
			o_off_q     <= '0;
			o_len_q     <= '0;
			o_fv_q      <= 1'b0;
			o_lba_q     <= '0;
			o_eof_q     <= 1'b0;
			o_last_q    <= 1'b0;
		end else begin
			// config writes must only be made while no item is in work; the block does not enforce this
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_SPC:       spc_q       <= cfg_data[7:0];
					REG_DATA_LBA:  data_lba_q  <= cfg_data;
					REG_ROOT_LBA:  root_lba_q  <= cfg_data;
					REG_ROOT_SIZE: root_size_q <= cfg_data[20:0];
					default: ;
				endcase
			end

			// downstream takes the result, unless a new one is loaded now
			if (ov_q && out_ready && (state_q != ST_EMIT)) begin
				ov_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (op_t'(operation))
							OP_LOAD: begin
								// table write goes straight to the RAM port
							end
							OP_OPEN: begin
								cur_q   <= {20'd0, start_cluster};
								sic_q   <= '0;
								pos_q   <= '0;
								size_q  <= file_bytes;
								dir_q   <= is_directory;
								root_q  <= 1'b0;
								cnt_q   <= '0;
								p_off_q <= '0;
								p_len_q <= '0;
								state_q <= ST_MUL;
							end
							OP_ROOT: begin
								cur_q    <= root_lba_q;
								sic_q    <= '0;
								pos_q    <= '0;
								size_q   <= {11'd0, root_size_q};
								dir_q    <= 1'b1;
								root_q   <= 1'b1;
								p_off_q  <= '0;
								p_len_q  <= '0;
								p_fv_q   <= 1'b1;
								p_lba_q  <= root_lba_q;
								p_eof_q  <= 1'b0;
								p_last_q <= 1'b1;
								state_q  <= ST_EMIT;
							end
							OP_READ: begin
								cnt_q   <= cnt_sat;
								state_q <= ST_CLAMP;
							end
							default: ;
						endcase
					end
				end

				ST_CLAMP: begin
					if (!dir_q && (left < {17'd0, cnt_q})) begin
						cnt_q <= left[14:0];
					end
					state_q <= ST_SEG;
				end

				ST_SEG: begin
					if (cnt_q == 15'd0) begin
						// nothing to copy: a single empty result
						p_off_q  <= seg_off;
						p_len_q  <= '0;
						p_fv_q   <= 1'b0;
						p_lba_q  <= '0;
						p_eof_q  <= 1'b0;
						p_last_q <= 1'b1;
						state_q  <= ST_EMIT;
					end else begin
						pos_q   <= seg_pos;
						cnt_q   <= seg_cnt;
						p_off_q <= seg_off;
						p_len_q <= seg_take;
						if (seg_bound && root_q) begin
							// root directory: contiguous sectors up to its size
							if (seg_pos >= size_q) begin
								p_fv_q   <= 1'b0;
								p_lba_q  <= '0;
								p_eof_q  <= 1'b1;
								p_last_q <= 1'b1;
							end else begin
								cur_q    <= cur_q + 32'd1;
								p_fv_q   <= 1'b1;
								p_lba_q  <= cur_q + 32'd1;
								p_eof_q  <= 1'b0;
								p_last_q <= (seg_cnt == 15'd0);
							end
							state_q <= ST_EMIT;
						end else begin
							p_fv_q   <= 1'b0;
							p_lba_q  <= '0;
							p_eof_q  <= 1'b0;
							p_last_q <= (seg_cnt == 15'd0);
							if (!seg_bound) begin
								state_q <= ST_EMIT;
							end else if (sic_nxt >= spc_eff) begin
								// cluster used up: follow the chain
								sic_q   <= '0;
								state_q <= ST_CH_A;
							end else begin
								sic_q   <= sic_nxt[6:0];
								state_q <= ST_CHK;
							end
						end
					end
				end

				ST_CH_A: begin
					// low byte address is on the RAM port this cycle
					if (fidx_lo >= FAT_LIM) begin
						cur_q   <= '0;
						state_q <= ST_CHK;
					end else begin
						state_q <= ST_CH_B;
					end
				end

				ST_CH_B: begin
					lo_q    <= ram_rdata;
					state_q <= ST_CH_C;
				end

				ST_CH_C: begin
					cur_q   <= {20'd0, entry_nxt};
					state_q <= ST_CHK;
				end

				ST_CHK: begin
					if (cur_q >= {20'd0, CHAIN_END}) begin
						// end of chain trims the file at this position
						size_q   <= pos_q;
						p_eof_q  <= 1'b1;
						p_last_q <= 1'b1;
						state_q  <= ST_EMIT;
					end else begin
						state_q <= ST_MUL;
					end
				end

				ST_MUL: begin
					prod_q  <= cl_m2 * spc_s;
					state_q <= ST_ADD;
				end

				ST_ADD: begin
					p_fv_q   <= 1'b1;
					p_lba_q  <= lba_sum;
					p_eof_q  <= 1'b0;
					p_last_q <= (cnt_q == 15'd0);
					state_q  <= ST_EMIT;
				end

				ST_EMIT: begin
					if (out_free) begin
						ov_q     <= 1'b1;
						o_off_q  <= p_off_q;
						o_len_q  <= p_len_q;
						o_fv_q   <= p_fv_q;
						o_lba_q  <= p_lba_q;
						o_eof_q  <= p_eof_q;
						o_last_q <= p_last_q;
						state_q  <= p_last_q ? ST_IDLE : ST_SEG;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/fat12_checker.sv =====
module fat12_checker
	import fat12_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  operation,
	input logic        out_valid,
	input logic        out_ready,
	input logic [8:0]  copy_offset,
	input logic [9:0]  copy_length,
	input logic        fetch_valid,
	input logic [31:0] fetch_lba,
	input logic        end_of_file,
	input logic        last
);

	// a stalled result holds its offset, length, lba and last
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(copy_offset) &&
		$stable(copy_length) && $stable(fetch_lba) && $stable(last))
		else $error("result changed while stalled");

	// a segment stays inside the sector buffer
	a_in_sector: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({2'b00, copy_offset} + {1'b0, copy_length}) <= 11'd512)
		else $error("segment crosses sector buffer");

	// end of file closes the request and asks for no sector
	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_file |-> last && !fetch_valid)
		else $error("end of file without last");

	// no fetch means no address
	a_lba_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !fetch_valid |-> fetch_lba == 32'd0)
		else $error("lba without fetch");

	// a table load never produces a result
	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (operation == OP_LOAD) && !out_valid |=> !out_valid)
		else $error("result after table load");

endmodule

bind fat12_file_sector_walker fat12_checker u_fat12_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.operation   (operation),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.copy_offset (copy_offset),
	.copy_length (copy_length),
	.fetch_valid (fetch_valid),
	.fetch_lba   (fetch_lba),
	.end_of_file (end_of_file),
	.last        (last)
);
